// ===== rtl/ackwin_pkg.sv =====
// ============================================================================
// ackwin_pkg
// Shared constants and types for the packet acknowledgement window tracker.
// ============================================================================
package ackwin_pkg;

    // default sizes
    localparam int WINDOW_DEPTH_DEF = 128;
    localparam int ACK_WIDTH_DEF    = 32;

    // fixed field widths
    localparam int SEQ_W = 32;
    localparam int OP_W  = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_RECV  = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    // control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ADD,
        ST_BUILD
    } state_t;

endpackage

// ===== rtl/ackwin_ram.sv =====
// ============================================================================
// ackwin_ram
// Generic single-write, single-read memory with a registered read port.
// ============================================================================
module ackwin_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/packet_ack_window_tracker_core.sv =====
// ============================================================================
// packet_ack_window_tracker_core
// Acknowledgement tracker for a reliable-datagram link: dedup window of
// received sequences, ack and ack bitfield, local sequence allocation and
// peer acknowledgement lookup.
// ============================================================================
// Usage:
//   A command word is taken at a rising edge with start high and busy low.
//   op 0 records a received packet and latches the peer's ack fields,
//   op 1 allocates the next local sequence, op 2 asks whether a local
//   sequence was acknowledged by the peer.
//   Every command gives exactly one result word, shown for one cycle with
//   done high; the receiver has no way to hold it off.
//   Ops 1, 2, 3 and op 0 with a zero sequence give their result in the
//   next cycle and busy stays low, so a command can be taken every cycle.
//   op 0 with a nonzero sequence walks the window in the memory, one
//   read per cycle on its single read port: once for dedup and, when
//   the ack advances, again to rebuild the ack bits. Each walk reads
//   every valid entry (at most WINDOW_DEPTH); busy is high meanwhile.
//   Reset clears the window fill, head, ack, ack bits, peer ack state and
//   the local counter; the window memory itself is not cleared and needs
//   no clearing pass.
// ============================================================================
module packet_ack_window_tracker_core #(
    parameter int WINDOW_DEPTH = ackwin_pkg::WINDOW_DEPTH_DEF,
    parameter int ACK_WIDTH    = ackwin_pkg::ACK_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ackwin_pkg::OP_W-1:0]   op,
    input  logic [ackwin_pkg::SEQ_W-1:0]  sequence_req,
    input  logic [ackwin_pkg::SEQ_W-1:0]  client_ack,
    input  logic [ackwin_pkg::SEQ_W-1:0]  client_ack_bits,
    input  logic [ackwin_pkg::SEQ_W-1:0]  asked_seq,
    output logic                          done,
    output logic [ackwin_pkg::SEQ_W-1:0]  ack,
    output logic [ackwin_pkg::SEQ_W-1:0]  ack_bits,
    output logic                          was_acked,
    output logic [ackwin_pkg::SEQ_W-1:0]  local_seq
);

    import ackwin_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int IW = $clog2(ACK_WIDTH);

    // state registers
    state_t               state_reg,     state_next;
    logic [CW-1:0]        count_reg,     count_next;
    logic [AW-1:0]        head_reg,      head_next;
    logic [SEQ_W-1:0]     highest_reg,   highest_next;
    logic [ACK_WIDTH-1:0] outbits_reg,   outbits_next;
    logic [SEQ_W-1:0]     peer_ack_reg,  peer_ack_next;
    logic [ACK_WIDTH-1:0] peer_bits_reg, peer_bits_next;
    logic [SEQ_W-1:0]     local_cnt_reg, local_cnt_next;

    // walk control
    logic [CW-1:0]        idx_reg,       idx_next;
    logic [AW-1:0]        ptr_reg,       ptr_next;
    logic                 rvalid_reg,    rvalid_next;
    logic                 found_reg,     found_next;
    logic                 hi_upd_reg,    hi_upd_next;
    logic                 done_reg,      done_next;

    // payload registers
    logic [SEQ_W-1:0]     seq_reg,       seq_next;
    logic                 was_acked_reg, was_acked_next;
    logic [SEQ_W-1:0]     local_seq_reg, local_seq_next;

    // memory port signals
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic                 ram_re;
    logic [SEQ_W-1:0]     ram_rdata;

    // datapath helpers
    logic                 walking;
    logic                 issue;
    logic [AW:0]          tail_sum;
    logic [AW-1:0]        tail_slot;
    logic [SEQ_W-1:0]     build_dist;
    logic                 build_hit;
    logic [ACK_WIDTH-1:0] build_mask;
    logic [SEQ_W-1:0]     query_dist;
    logic                 query_hit;

    // advance a window slot with wrap at the depth
    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == AW'(WINDOW_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    // window memory
    ackwin_ram #(
        .WIDTH (SEQ_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (seq_reg),
        .re    (ram_re),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    // one read per cycle while walking the valid entries
    assign walking = (state_reg == ST_SCAN) || (state_reg == ST_BUILD);
    assign issue   = walking && (idx_reg < count_reg);
    assign ram_re  = issue;

    // slot just past the newest entry
    assign tail_sum  = (AW+1)'(head_reg) + (AW+1)'(count_reg);
    assign tail_slot = (tail_sum >= (AW+1)'(WINDOW_DEPTH))
                     ? AW'(tail_sum - (AW+1)'(WINDOW_DEPTH))
                     : AW'(tail_sum);

    // ack bit contributed by the entry read back during rebuild
    assign build_dist = highest_reg - ram_rdata - 1'b1;
    assign build_hit  = (ram_rdata < highest_reg) && (build_dist < SEQ_W'(ACK_WIDTH));
    assign build_mask = ACK_WIDTH'(1) << build_dist[IW-1:0];

    // peer acknowledgement lookup
    assign query_dist = peer_ack_reg - asked_seq - 1'b1;
    always_comb
    begin
        if (asked_seq == '0)
            query_hit = 1'b0;
        else if (asked_seq == peer_ack_reg)
            query_hit = 1'b1;
        else if (asked_seq > peer_ack_reg)
            query_hit = 1'b0;
        else if (query_dist >= SEQ_W'(ACK_WIDTH))
            query_hit = 1'b0;
        else
            query_hit = peer_bits_reg[query_dist[IW-1:0]];
    end

    // next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        highest_next   = highest_reg;
        outbits_next   = outbits_reg;
        peer_ack_next  = peer_ack_reg;
        peer_bits_next = peer_bits_reg;
        local_cnt_next = local_cnt_reg;
        idx_next       = idx_reg;
        ptr_next       = ptr_reg;
        rvalid_next    = issue;
        found_next     = found_reg;
        hi_upd_next    = hi_upd_reg;
        done_next      = 1'b0;
        seq_next       = seq_reg;
        was_acked_next = was_acked_reg;
        local_seq_next = local_seq_reg;
        ram_we         = 1'b0;
        ram_waddr      = tail_slot;

        // walk pointer steps with each issued read
        if (issue)
        begin
            idx_next = idx_reg + 1'b1;
            ptr_next = slot_inc(ptr_reg);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    was_acked_next = 1'b0;
                    local_seq_next = '0;
                    done_next      = 1'b1;
                    case (op)
                        OP_RECV:
                        begin
                            peer_ack_next  = client_ack;
                            peer_bits_next = ACK_WIDTH'(client_ack_bits);
                            if (sequence_req != '0)
                            begin
                                done_next   = 1'b0;
                                seq_next    = sequence_req;
                                hi_upd_next = (sequence_req > highest_reg);
                                found_next  = 1'b0;
                                idx_next    = '0;
                                ptr_next    = head_reg;
                                state_next  = ST_SCAN;
                            end
                        end
                        OP_ALLOC:
                        begin
                            local_cnt_next = local_cnt_reg + 1'b1;
                            local_seq_next = local_cnt_reg + 1'b1;
                        end
                        OP_QUERY:
                        begin
                            was_acked_next = query_hit;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (rvalid_reg && (ram_rdata == seq_reg))
                    found_next = 1'b1;
                if (!issue && !rvalid_reg)
                    state_next = ST_ADD;
            end

            ST_ADD:
            begin
                // append when new, dropping the oldest entry when full
                if (!found_reg)
                begin
                    ram_we = 1'b1;
                    if (count_reg < CW'(WINDOW_DEPTH))
                    begin
                        ram_waddr  = tail_slot;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ram_waddr = head_reg;
                        head_next = slot_inc(head_reg);
                    end
                end
                if (hi_upd_reg)
                begin
                    highest_next = seq_reg;
                    outbits_next = '0;
                    idx_next     = '0;
                    ptr_next     = head_next;
                    state_next   = ST_BUILD;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_BUILD:
            begin
                if (rvalid_reg && build_hit)
                    outbits_next = outbits_reg | build_mask;
                if (!issue && !rvalid_reg)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            highest_reg   <= '0;
            outbits_reg   <= '0;
            peer_ack_reg  <= '0;
            peer_bits_reg <= '0;
            local_cnt_reg <= '0;
            idx_reg       <= '0;
            ptr_reg       <= '0;
            rvalid_reg    <= 1'b0;
            found_reg     <= 1'b0;
            hi_upd_reg    <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            highest_reg   <= highest_next;
            outbits_reg   <= outbits_next;
            peer_ack_reg  <= peer_ack_next;
            peer_bits_reg <= peer_bits_next;
            local_cnt_reg <= local_cnt_next;
            idx_reg       <= idx_next;
            ptr_reg       <= ptr_next;
            rvalid_reg    <= rvalid_next;
            found_reg     <= found_next;
            hi_upd_reg    <= hi_upd_next;
            done_reg      <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        seq_reg       <= seq_next;
        was_acked_reg <= was_acked_next;
        local_seq_reg <= local_seq_next;
    end

    // result word
    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign ack       = highest_reg;
    assign ack_bits  = SEQ_W'(outbits_reg);
    assign was_acked = was_acked_reg;
    assign local_seq = local_seq_reg;

endmodule

// ===== rtl/ackwin_chk.sv =====
// ============================================================================
// ackwin_chk
// Port-level checks for the acknowledgement window tracker, bound to the
// top level.
// ============================================================================
module ackwin_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [ackwin_pkg::OP_W-1:0]   op,
    input logic [ackwin_pkg::SEQ_W-1:0]  sequence_req,
    input logic                          done,
    input logic [ackwin_pkg::SEQ_W-1:0]  ack
);

    import ackwin_pkg::*;

    // short commands answer in the next cycle without going busy
    a_short_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op != OP_RECV || sequence_req == '0)) |=> (done && !busy))
        else $error("short command did not finish in one cycle");

    // a result word is only shown once the block is idle again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word shown while busy");

    // busy only rises after a word was taken
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a command word");

    // the ack never moves backward
    a_ack_mono: assert property (@(posedge clk) disable iff (!rst_n)
        ack >= $past(ack))
        else $error("ack decreased");

endmodule

bind packet_ack_window_tracker_core ackwin_chk u_ackwin_chk (.*);
